[src/ams_pkg.sv]
package ams_pkg;

    // Storage sizes; depths are powers of two so index wrap is a plain mask
    localparam int PROG_DEPTH = 256;
    localparam int DATA_DEPTH = 256;
    localparam int ACC_WIDTH  = 32;

    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int DATA_AW = $clog2(DATA_DEPTH);

    // Program word: opcode in the high nibble, operand address below it
    localparam int OPC_WIDTH  = 4;
    localparam int OPND_WIDTH = 8;
    localparam int WORD_WIDTH = OPC_WIDTH + OPND_WIDTH;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    // Opcodes
    localparam logic [OPC_WIDTH-1:0] OP_LOAD  = 4'd1;
    localparam logic [OPC_WIDTH-1:0] OP_ADD   = 4'd2;
    localparam logic [OPC_WIDTH-1:0] OP_STORE = 4'd3;
    localparam logic [OPC_WIDTH-1:0] OP_SUB   = 4'd4;
    localparam logic [OPC_WIDTH-1:0] OP_IN    = 4'd5;
    localparam logic [OPC_WIDTH-1:0] OP_OUT   = 4'd6;
    localparam logic [OPC_WIDTH-1:0] OP_END   = 4'd7;
    localparam logic [OPC_WIDTH-1:0] OP_JMP   = 4'd8;
    localparam logic [OPC_WIDTH-1:0] OP_SKIPZ = 4'd9;

    typedef struct packed {
        logic                         command;
        logic [7:0]                   prog_index;
        logic [OPC_WIDTH-1:0]         op_code;
        logic [OPND_WIDTH-1:0]        operand_address;
        logic signed [31:0]           input_value;
    } ams_in_t;

    typedef struct packed {
        logic [7:0]                   executed_pc;
        logic signed [31:0]           acc_value;
        logic                         out_valid;
        logic signed [31:0]           out_value;
        logic                         halted;
        logic                         bad_opcode;
    } ams_out_t;

    // Data store access for one cycle
    typedef struct packed {
        logic                         rd_en;
        logic [DATA_AW-1:0]           rd_addr;
        logic                         wr_en;
        logic [DATA_AW-1:0]           wr_addr;
        logic [ACC_WIDTH-1:0]         wr_data;
    } ams_dmem_req_t;

endpackage

[src/ams_dmem.sv]
module ams_dmem (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ams_pkg::ams_dmem_req_t req,
    output logic [ams_pkg::ACC_WIDTH-1:0] q
);
    import ams_pkg::*;

    logic [ACC_WIDTH-1:0]  mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] valid_reg;
    logic [ACC_WIDTH-1:0]  rd_data_reg;
    logic                  rd_valid_reg;

    // Per-entry written flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // Storage array, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign q = rd_valid_reg ? rd_data_reg : '0;

endmodule

[src/accumulator_machine_step.sv]
// Channel   Ports              Handshake
// --------  -----------------  ---------------------------------------------
// item      start, item        taken at a rising edge with start high, busy low
// result    done, result       one item per done pulse, one cycle, no stall
//
// Every item, program write or instruction, goes through the same steps: the
// program store written or read at acceptance, then the data store read, then
// execute. The next item is taken in the execute cycle, with the new counter
// forwarded to the program store address. The result is registered from the
// execute state. Reset clears counter, accumulator, halt flag and the data
// store's written flags at once; the block is ready right after reset.
module accumulator_machine_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ams_pkg::ams_in_t  item,
    output logic              done,
    output ams_pkg::ams_out_t result
);
    import ams_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic                   cmd_reg;
    logic signed [31:0]     in_value_reg;
    logic [WORD_WIDTH-1:0]  prog_q_reg;
    logic [PROG_AW-1:0]     pc_reg, pc_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic                   halt_reg, halt_next;
    logic                   done_reg;
    ams_out_t               result_reg;

    logic [WORD_WIDTH-1:0]  prog_mem [PROG_DEPTH];

    logic                   accept;
    logic                   exec_run;
    logic [OPC_WIDTH-1:0]   ins_op;
    logic [OPND_WIDTH-1:0]  ins_addr;
    logic [DATA_AW-1:0]     data_addr;
    logic [PROG_AW-1:0]     jump_pc;
    logic [PROG_AW-1:0]     pc_inc;
    logic [PROG_AW-1:0]     wr_slot;
    logic [ACC_WIDTH-1:0]   dmem_q;
    logic                   store_en;
    logic                   out_en;
    logic                   bad_en;
    ams_dmem_req_t          dmem_req;

    assign busy   = (state_reg == S_FETCH);
    assign accept = start && !busy;

    // Instruction fields
    assign ins_op    = prog_q_reg[WORD_WIDTH-1:OPND_WIDTH];
    assign ins_addr  = prog_q_reg[OPND_WIDTH-1:0];
    assign data_addr = DATA_AW'(32'(ins_addr) % DATA_DEPTH);
    assign jump_pc   = PROG_AW'(32'(ins_addr) % PROG_DEPTH);
    assign pc_inc    = pc_reg + 1'b1;
    assign wr_slot   = PROG_AW'(32'(item.prog_index) % PROG_DEPTH);
    assign exec_run  = (state_reg == S_EXEC) && (cmd_reg == CMD_RUN) && !halt_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_FETCH : S_IDLE;
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  state_next = accept ? S_FETCH : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Program store: write on a program item, else fetch at the
    // forwarded counter
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (item.command == CMD_WRITE)
            begin
                prog_mem[wr_slot] <= {item.op_code, item.operand_address};
            end
            else
            begin
                prog_q_reg <= prog_mem[pc_next];
            end
        end
    end

    // Item payload kept for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= item.command;
            in_value_reg <= item.input_value;
        end
    end

    // Execute
    always_comb
    begin
        acc_next  = acc_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        store_en  = 1'b0;
        out_en    = 1'b0;
        bad_en    = 1'b0;
        if (exec_run)
        begin
            pc_next = pc_inc;
            case (ins_op)
                OP_LOAD:  acc_next = dmem_q;
                OP_ADD:   acc_next = acc_reg + dmem_q;
                OP_STORE: store_en = 1'b1;
                OP_SUB:   acc_next = acc_reg - dmem_q;
                OP_IN:    acc_next = ACC_WIDTH'(in_value_reg);
                OP_OUT:   out_en = 1'b1;
                OP_END:   halt_next = 1'b1;
                OP_JMP:   pc_next = jump_pc;
                OP_SKIPZ:
                begin
                    if (acc_reg == '0)
                    begin
                        pc_next = pc_inc + 1'b1;
                    end
                end
                default:  bad_en = 1'b1;
            endcase
        end
    end

    // Data store: read in the fetch cycle, write back in execute
    always_comb
    begin
        dmem_req.rd_en   = (state_reg == S_FETCH);
        dmem_req.rd_addr = data_addr;
        dmem_req.wr_en   = store_en;
        dmem_req.wr_addr = data_addr;
        dmem_req.wr_data = acc_reg;
    end

    ams_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dmem_req),
        .q     (dmem_q)
    );

    // Architectural state and sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            acc_reg   <= '0;
            halt_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_next;
            halt_reg  <= halt_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            result_reg.executed_pc <= 8'(pc_reg);
            result_reg.acc_value   <= 32'(acc_next);
            result_reg.out_valid   <= out_en;
            result_reg.out_value   <= out_en ? 32'(acc_reg) : '0;
            result_reg.halted      <= halt_next;
            result_reg.bad_opcode  <= bad_en;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_fetch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> $past(accept))
        else $error("fetch cycle without an accepted item");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> $stable(pc_reg))
        else $error("counter moved while halted");

    a_dmem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(dmem_req.rd_en && dmem_req.wr_en))
        else $error("data store read and write in the same cycle");

endmodule

[bench/accumulator_machine_step_tb.sv]
module accumulator_machine_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ams_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    // Opcodes the machine does not know
    localparam logic [OPC_WIDTH-1:0] OP_BLANK = 4'h0;
    localparam logic [OPC_WIDTH-1:0] OP_TOP   = 4'hF;

    // Predicts each result from its own copy of the machine state
    class acc_machine_model;
        bit [WORD_WIDTH-1:0] prog_mem [PROG_DEPTH];
        bit                  prog_written [PROG_DEPTH];
        bit [ACC_WIDTH-1:0]  data_mem [DATA_DEPTH];
        bit [ACC_WIDTH-1:0]  acc;
        bit [PROG_AW-1:0]    pc;
        bit                  halt;
        ams_out_t            expected_results [$];
        int                  fault_count;

        // Step the machine for one accepted item and queue its result
        function void record_item(ams_in_t it);
            ams_out_t             want;
            bit [OPC_WIDTH-1:0]   opc;
            bit [OPND_WIDTH-1:0]  opnd;
            bit [PROG_AW-1:0]     nxt;
            want = '0;
            want.executed_pc = pc;
            if (it.command == CMD_WRITE)
            begin
                prog_mem[it.prog_index] = {it.op_code, it.operand_address};
                prog_written[it.prog_index] = 1'b1;
            end
            else if (!halt)
            begin
                {opc, opnd} = prog_mem[pc];
                nxt = pc + 1'b1;
                case (opc)
                    OP_LOAD:  acc = data_mem[opnd];
                    OP_ADD:   acc = acc + data_mem[opnd];
                    OP_STORE: data_mem[opnd] = acc;
                    OP_SUB:   acc = acc - data_mem[opnd];
                    OP_IN:    acc = it.input_value;
                    OP_OUT:
                    begin
                        want.out_valid = 1'b1;
                        want.out_value = acc;
                    end
                    OP_END:   halt = 1'b1;
                    OP_JMP:   nxt = opnd;
                    OP_SKIPZ:
                    begin
                        if (acc == '0)
                            nxt = pc + 2'd2;
                    end
                    default:  want.bad_opcode = 1'b1;
                endcase
                pc = nxt;
            end
            want.acc_value = acc;
            want.halted = halt;
            expected_results.push_back(want);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                fault_count++;
            end
        endfunction

        // Compare one strobed result with the oldest prediction
        function void check_result(ams_out_t got);
            ams_out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending: executed_pc %0h", got.executed_pc);
                fault_count++;
                return;
            end
            want = expected_results.pop_front();
            check_field("executed_pc", want.executed_pc, got.executed_pc);
            check_field("acc_value", want.acc_value, got.acc_value);
            check_field("out_valid", want.out_valid, got.out_valid);
            check_field("out_value", want.out_value, got.out_value);
            check_field("halted", want.halted, got.halted);
            check_field("bad_opcode", want.bad_opcode, got.bad_opcode);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ams_in_t  item;
    logic     done;
    ams_out_t result;

    acc_machine_model machine = new();
    int items_sent;
    int cycle_count;

    accumulator_machine_step u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random program word; never END, which would halt the run for good
    function automatic logic [WORD_WIDTH-1:0] random_word();
        logic [OPC_WIDTH-1:0]  op;
        logic [OPND_WIDTH-1:0] addr;
        case ($urandom_range(0, 8))
            0: op = OP_LOAD;
            1: op = OP_ADD;
            2: op = OP_STORE;
            3: op = OP_SUB;
            4: op = OP_IN;
            5: op = OP_OUT;
            6: op = OP_JMP;
            7: op = OP_SKIPZ;
            default: op = ($urandom_range(0, 6) == 0) ? OP_BLANK
                                                     : OP_SKIPZ + 4'($urandom_range(1, 6));
        endcase
        // Small addresses often, so stored data gets loaded back
        addr = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        return {op, addr};
    endfunction

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return '1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Present one item, hold it until taken, then maybe idle a little
    task automatic send_item(input ams_in_t it, input int gap_pct);
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        machine.record_item(it);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic write_word(input logic [7:0] slot, input logic [WORD_WIDTH-1:0] word,
                              input int gap_pct);
        ams_in_t it;
        it.command = CMD_WRITE;
        it.prog_index = slot;
        {it.op_code, it.operand_address} = word;
        it.input_value = random_value();
        send_item(it, gap_pct);
    endtask

    // Run one instruction; an unwritten slot at the counter is filled first
    task automatic run_step(input logic signed [31:0] value, input int gap_pct);
        ams_in_t it;
        if (!machine.halt && !machine.prog_written[machine.pc])
            write_word(machine.pc, random_word(), gap_pct);
        it.command = CMD_RUN;
        it.prog_index = 8'($urandom);
        it.op_code = 4'($urandom);
        it.operand_address = 8'($urandom);
        it.input_value = value;
        send_item(it, gap_pct);
    endtask

    // Mostly execution, with rewrites of the current slot or any slot
    task automatic random_phase(input int stop_at, input int gap_pct);
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 20)
                write_word(($urandom_range(0, 1) != 0) ? machine.pc : 8'($urandom),
                           random_word(), gap_pct);
            else
                run_step(random_value(), gap_pct);
        end
    endtask

    // Results are strobed for one cycle and cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
            machine.check_result(result);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short program touching every opcode but END, the counter wrap and both skip cases
        write_word(8'h00, {OP_IN, 8'h00}, 13);
        write_word(8'h01, {OP_STORE, 8'hFF}, 13);
        write_word(8'h02, {OP_IN, 8'h00}, 13);
        write_word(8'h03, {OP_ADD, 8'hFF}, 13);
        write_word(8'h04, {OP_SUB, 8'hFF}, 13);
        write_word(8'h05, {OP_LOAD, 8'hFF}, 13);
        write_word(8'h06, {OP_OUT, 8'h00}, 13);
        write_word(8'h07, {OP_SKIPZ, 8'h00}, 13);
        write_word(8'h08, {OP_JMP, 8'hFE}, 13);
        write_word(8'hFE, {OP_BLANK, 8'h00}, 13);
        write_word(8'hFF, {OP_TOP, 8'hFF}, 13);

        // First pass: largest values, skip not taken
        run_step(32'sh7FFF_FFFF, 13);
        run_step(random_value(), 13);
        run_step(32'sh8000_0000, 13);
        repeat (8) run_step(random_value(), 13);

        // Second pass after the wrap to slot 0: zero accumulator, skip taken
        run_step('0, 13);
        run_step(random_value(), 13);
        run_step('0, 13);
        repeat (5) run_step(random_value(), 13);

        random_phase(500, 13);
        random_phase(980, 53);
        random_phase(1450, 0);

        // Halt, then runs and a write that must leave the state alone
        write_word(machine.pc, {OP_END, 8'($urandom)}, 13);
        run_step(random_value(), 13);
        run_step(random_value(), 13);
        write_word(8'($urandom), random_word(), 13);
        run_step(random_value(), 0);
        run_step(random_value(), 0);
        start <= 1'b0;

        while (machine.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (machine.fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
